/* design/bpws_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpws_pkg
// Shared types, constants and arithmetic helpers for the box physics
// world step unit.
// ----------------------------------------------------------------------------
package bpws_pkg;

    localparam int MAX_BOXES = 16;
    localparam int IDX_W     = $clog2(MAX_BOXES);
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);
    localparam int STEP_BITS = 16;

    localparam logic [15:0] TIME_STEP_RST = 16'd1049;
    localparam logic [19:0] GRAVITY_RST   = 20'd10276;
    localparam logic [19:0] THRESH_RST    = 20'd6554;

    typedef enum logic [1:0] {
        OP_LOAD      = 2'd0,
        OP_SET_FORCE = 2'd1,
        OP_STEP      = 2'd2,
        OP_READ      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_BOX_COUNT   = 2'd0,
        REG_TIME_STEP   = 2'd1,
        REG_GRAVITY     = 2'd2,
        REG_STOP_THRESH = 2'd3
    } cfg_reg_t;

    typedef logic signed [31:0] coord_t;
    typedef logic        [30:0] ext_t;
    typedef coord_t [2:0] vec3_t;
    typedef ext_t   [2:0] ext3_t;
    typedef logic signed [48:0] prod_t;
    typedef logic signed [32:0] step_t;

    typedef struct packed {
        logic [3:0] index;
        vec3_t      center;
        vec3_t      force_vec;
        logic       supported;
        logic       last_box;
    } out_item_t;

    // Closed interval test on doubled coordinates.
    function automatic logic span_meets(input coord_t a, input ext_t la,
                                        input coord_t b, input ext_t lb);
        logic signed [34:0] a2;
        logic signed [34:0] b2;
        logic signed [34:0] lae;
        logic signed [34:0] lbe;
        a2  = {{2{a[31]}}, a, 1'b0};
        b2  = {{2{b[31]}}, b, 1'b0};
        lae = {4'b0, la};
        lbe = {4'b0, lb};
        return !((a2 + lae < b2 - lbe) || (a2 - lae > b2 + lbe));
    endfunction

    function automatic logic boxes_meet(input vec3_t ca, input ext3_t la,
                                        input vec3_t cb, input ext3_t lb);
        return span_meets(ca[0], la[0], cb[0], lb[0]) &&
               span_meets(ca[1], la[1], cb[1], lb[1]) &&
               span_meets(ca[2], la[2], cb[2], lb[2]);
    endfunction

    // Center of box a lies over the x/z footprint of box b.
    function automatic logic over_footprint(input vec3_t ca, input vec3_t cb,
                                            input ext3_t lb);
        return span_meets(ca[0], '0, cb[0], lb[0]) &&
               span_meets(ca[2], '0, cb[2], lb[2]);
    endfunction

    // Scale a product back by the step fraction, halves away from zero.
    function automatic step_t round_step(input prod_t p);
        logic [48:0] mag;
        logic [48:0] r;
        mag = p[48] ? $unsigned(-p) : $unsigned(p);
        r   = (mag + (49'd1 << (STEP_BITS - 1))) >> STEP_BITS;
        return p[48] ? -$signed(r[32:0]) : $signed(r[32:0]);
    endfunction

    function automatic vec3_t half_floor(input vec3_t f);
        vec3_t h;
        for (int k = 0; k < 3; k++)
        begin
            h[k] = f[k] >>> 1;
        end
        return h;
    endfunction

endpackage

/* design/bpws_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpws_req_if
// Request channel: one item is one box operation or a world step.
// ----------------------------------------------------------------------------
interface bpws_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [3:0]  box_index;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0] length_x;
    logic [30:0] length_y;
    logic [30:0] length_z;
    logic signed [31:0] push_x;
    logic signed [31:0] push_y;
    logic signed [31:0] push_z;

    modport source (output valid, operation, box_index, center_x, center_y, center_z,
                    length_x, length_y, length_z, push_x, push_y, push_z,
                    input ready);
    modport sink (input valid, operation, box_index, center_x, center_y, center_z,
                  length_x, length_y, length_z, push_x, push_y, push_z,
                  output ready);
endinterface

/* design/bpws_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpws_rsp_if
// Result channel: one item reports the state of one box.
// ----------------------------------------------------------------------------
interface bpws_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  out_index;
    logic signed [31:0] out_center_x;
    logic signed [31:0] out_center_y;
    logic signed [31:0] out_center_z;
    logic signed [31:0] out_force_x;
    logic signed [31:0] out_force_y;
    logic signed [31:0] out_force_z;
    logic        supported;
    logic        last_box;

    modport source (output valid, out_index, out_center_x, out_center_y, out_center_z,
                    out_force_x, out_force_y, out_force_z, supported, last_box,
                    input ready);
    modport sink (input valid, out_index, out_center_x, out_center_y, out_center_z,
                  out_force_x, out_force_y, out_force_z, supported, last_box,
                  output ready);
endinterface

/* design/bpws_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpws_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bpws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/box_physics_world_step_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_physics_world_step_unit
// Table of axis-aligned boxes with a sequencer that runs one world step.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req, results leave on rsp (valid/ready).
// Load, set force and read each give one result, read back through
// ST_OREAD and ST_OCAP. A world step over n boxes in use gives n results in
// index order, the last one flagged by last_box; an empty world gives none.
// Per box the sequencer reads the box, scans the boxes for support unless
// it rests on the floor, moves it through one shared multiplier, writes the
// center, scans again to push forces, decays its force and writes it back;
// then it reads out each box in turn for its result. The scans are bound by
// the single read port of the box memories, one box per cycle.
// req is ready only while the sequencer is idle. One output register holds
// a result; a stalled receiver stalls the sequencer at the next result, but
// a new item can be taken while the last result still waits.
// Reset clears the control state and the configuration registers to their defaults; the
// box memories are not cleared and a box must be loaded before use.
// Configuration must be written through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce this.
module box_physics_world_step_unit (
    input  logic        clk,
    input  logic        rst_n,
    bpws_req_if.sink    req,
    bpws_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    localparam int IW = bpws_pkg::IDX_W;
    localparam int CW = bpws_pkg::CNT_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_OREAD, ST_OCAP, ST_LOADI, ST_GETI, ST_SUP, ST_MOVE,
        ST_WRC, ST_PUSH, ST_DECAY, ST_WRF, ST_ESEND, ST_ECAP
    } state_t;

    state_t state_reg, state_next;
    logic [4:0]  box_count_reg;
    logic [15:0] time_step_reg;
    logic [19:0] gravity_reg;
    logic [19:0] thresh_reg;
    logic [3:0]  op_idx_reg, op_idx_next;
    logic [CW-1:0] n_reg, n_next;
    logic [IW-1:0] i_reg, i_next;
    logic [CW-1:0] rd_j_reg, rd_j_next;
    logic          ev_valid_reg, ev_valid_next;
    logic [IW-1:0] ev_j_reg, ev_j_next;
    logic [1:0]    k_reg, k_next;
    logic          rest_reg, rest_next;
    logic          hit_reg, hit_next;
    logic [bpws_pkg::MAX_BOXES-1:0] sup_reg, sup_next;
    bpws_pkg::vec3_t ci_reg, ci_next;
    bpws_pkg::ext3_t ei_reg, ei_next;
    bpws_pkg::vec3_t fi_reg, fi_next;
    bpws_pkg::vec3_t vi_reg, vi_next;
    bpws_pkg::prod_t prod_reg, prod_next;
    logic            out_valid_reg, out_valid_next;
    bpws_pkg::out_item_t out_reg, out_next;

    logic            c_we, f_we;
    logic [IW-1:0]   c_waddr, f_waddr, raddr;
    bpws_pkg::vec3_t c_wdata, f_wdata;
    bpws_pkg::ext3_t e_wdata;
    logic [188:0]    b_rbits;
    logic [95:0]     c_rbits, f_rbits;
    logic [92:0]     e_rbits;
    bpws_pkg::vec3_t c_rd, f_rd;
    bpws_pkg::ext3_t e_rd;

    logic [CW-1:0]   n_clip;
    logic            out_free;
    logic            idx_ok;
    logic            scan_done;
    logic            i_last;
    logic signed [33:0] bottom2;
    logic [1:0]         km1;
    bpws_pkg::step_t    rstep;
    logic signed [33:0] csum;
    logic signed [33:0] dval;
    logic [33:0]        dmag;

    // Center and extent of a box share one entry.
    bpws_ram #(.WIDTH(189), .DEPTH(bpws_pkg::MAX_BOXES)) u_box_ram (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata({e_wdata, c_wdata}),
        .raddr(raddr), .rdata(b_rbits)
    );
    bpws_ram #(.WIDTH(96), .DEPTH(bpws_pkg::MAX_BOXES)) u_force_ram (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(raddr), .rdata(f_rbits)
    );

    assign c_rbits = b_rbits[95:0];
    assign e_rbits = b_rbits[188:96];
    assign c_rd = c_rbits;
    assign e_rd = e_rbits;
    assign f_rd = f_rbits;

    assign n_clip = (int'(box_count_reg) > bpws_pkg::MAX_BOXES) ?
                    CW'(bpws_pkg::MAX_BOXES) : CW'(box_count_reg);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign idx_ok    = int'(op_idx_reg) < bpws_pkg::MAX_BOXES;
    assign scan_done = !ev_valid_reg && (rd_j_reg >= n_reg);
    assign i_last    = (CW'(i_reg) + CW'(1)) == n_reg;
    assign km1       = k_reg - 2'd1;
    assign rstep     = bpws_pkg::round_step(prod_reg);
    assign bottom2   = {{2{c_rd[1][31]}}, c_rd[1]} + {{2{c_rd[1][31]}}, c_rd[1]}
                       - {3'b0, e_rd[1]};

    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        op_idx_next    = op_idx_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        rd_j_next      = rd_j_reg;
        ev_valid_next  = ev_valid_reg;
        ev_j_next      = ev_j_reg;
        k_next         = k_reg;
        rest_next      = rest_reg;
        hit_next       = hit_reg;
        sup_next       = sup_reg;
        ci_next        = ci_reg;
        ei_next        = ei_reg;
        fi_next        = fi_reg;
        vi_next        = vi_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_next       = out_reg;
        c_we    = 1'b0;
        f_we    = 1'b0;
        c_waddr = i_reg;
        f_waddr = i_reg;
        c_wdata = ci_reg;
        e_wdata = {req.length_z, req.length_y, req.length_x};
        f_wdata = vi_reg;
        raddr   = i_reg;
        csum    = '0;
        dval    = '0;
        dmag    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_idx_next = req.box_index;
                    c_waddr = IW'(req.box_index);
                    f_waddr = IW'(req.box_index);
                    c_wdata = {req.center_z, req.center_y, req.center_x};
                    f_wdata = {req.push_z, req.push_y, req.push_x};
                    unique case (bpws_pkg::op_t'(req.operation))
                        bpws_pkg::OP_LOAD:
                        begin
                            if (int'(req.box_index) < bpws_pkg::MAX_BOXES)
                            begin
                                c_we = 1'b1;
                                f_we = 1'b1;
                            end
                            state_next = ST_OREAD;
                        end
                        bpws_pkg::OP_SET_FORCE:
                        begin
                            f_we = int'(req.box_index) < bpws_pkg::MAX_BOXES;
                            state_next = ST_OREAD;
                        end
                        bpws_pkg::OP_READ:
                        begin
                            state_next = ST_OREAD;
                        end
                        bpws_pkg::OP_STEP:
                        begin
                            n_next = n_clip;
                            i_next = '0;
                            if (n_clip != '0)
                            begin
                                state_next = ST_LOADI;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_OREAD:
            begin
                raddr = IW'(op_idx_reg);
                state_next = ST_OCAP;
            end
            ST_OCAP:
            begin
                raddr = IW'(op_idx_reg);
                if (out_free)
                begin
                    out_next.index     = op_idx_reg;
                    out_next.center    = idx_ok ? c_rd : '0;
                    out_next.force_vec = idx_ok ? f_rd : '0;
                    out_next.supported = 1'b0;
                    out_next.last_box  = 1'b1;
                    out_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            ST_LOADI:
            begin
                state_next = ST_GETI;
            end
            ST_GETI:
            begin
                ci_next = c_rd;
                ei_next = e_rd;
                fi_next = f_rd;
                k_next  = '0;
                rest_next     = !(bottom2 > 0);
                rd_j_next     = '0;
                ev_valid_next = 1'b0;
                state_next    = (bottom2 > 0) ? ST_SUP : ST_MOVE;
            end
            ST_SUP, ST_PUSH:
            begin
                raddr = rd_j_reg[IW-1:0];
                if (rd_j_reg < n_reg)
                begin
                    rd_j_next     = rd_j_reg + CW'(1);
                    ev_valid_next = 1'b1;
                    ev_j_next     = rd_j_reg[IW-1:0];
                end
                else
                begin
                    ev_valid_next = 1'b0;
                end
                if (state_reg == ST_SUP)
                begin
                    if (ev_valid_reg && ev_j_reg != i_reg &&
                        bpws_pkg::boxes_meet(ci_reg, ei_reg, c_rd, e_rd) &&
                        bpws_pkg::over_footprint(ci_reg, c_rd, e_rd))
                    begin
                        rest_next  = 1'b1;
                        state_next = ST_MOVE;
                    end
                    else if (scan_done)
                    begin
                        state_next = ST_MOVE;
                    end
                end
                else
                begin
                    // Pushed boxes take half of the mover's force.
                    f_waddr = ev_j_reg;
                    f_wdata = bpws_pkg::half_floor(fi_reg);
                    if (ev_valid_reg && ev_j_reg != i_reg &&
                        bpws_pkg::boxes_meet(ci_reg, ei_reg, c_rd, e_rd))
                    begin
                        f_we     = 1'b1;
                        hit_next = 1'b1;
                    end
                    if (scan_done)
                    begin
                        vi_next    = hit_reg ? '0 : fi_reg;
                        k_next     = '0;
                        state_next = ST_DECAY;
                    end
                end
            end
            ST_MOVE:
            begin
                // Multiply one axis while the previous product is applied.
                if (k_reg != 2'd3)
                begin
                    prod_next = fi_reg[k_reg] * $signed({1'b0, time_step_reg});
                end
                if (k_reg != 2'd0)
                begin
                    csum = {{2{ci_reg[km1][31]}}, ci_reg[km1]} + {rstep[32], rstep}
                           - ((km1 == 2'd1 && !rest_reg) ? {14'b0, gravity_reg} : 34'sd0);
                    ci_next[km1] = csum[31:0];
                end
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    state_next = ST_WRC;
                end
            end
            ST_WRC:
            begin
                c_we          = 1'b1;
                e_wdata       = ei_reg;
                rd_j_next     = '0;
                ev_valid_next = 1'b0;
                hit_next      = 1'b0;
                state_next    = ST_PUSH;
            end
            ST_DECAY:
            begin
                if (k_reg != 2'd3)
                begin
                    prod_next = vi_reg[k_reg] * $signed({1'b0, time_step_reg});
                end
                if (k_reg != 2'd0)
                begin
                    dval = {{2{vi_reg[km1][31]}}, vi_reg[km1]} - {rstep[32], rstep};
                    dmag = dval[33] ? $unsigned(-dval) : $unsigned(dval);
                    vi_next[km1] = (dmag < {14'b0, thresh_reg}) ? '0 : dval[31:0];
                end
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    state_next = ST_WRF;
                end
            end
            ST_WRF:
            begin
                f_we = 1'b1;
                sup_next[i_reg] = rest_reg;
                if (i_last)
                begin
                    i_next     = '0;
                    state_next = ST_ESEND;
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = ST_LOADI;
                end
            end
            ST_ESEND:
            begin
                state_next = ST_ECAP;
            end
            ST_ECAP:
            begin
                if (out_free)
                begin
                    out_next.index     = 4'(i_reg);
                    out_next.center    = c_rd;
                    out_next.force_vec = f_rd;
                    out_next.supported = sup_reg[i_reg];
                    out_next.last_box  = i_last;
                    out_valid_next     = 1'b1;
                    if (i_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + IW'(1);
                        state_next = ST_ESEND;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            box_count_reg <= '0;
            time_step_reg <= bpws_pkg::TIME_STEP_RST;
            gravity_reg   <= bpws_pkg::GRAVITY_RST;
            thresh_reg    <= bpws_pkg::THRESH_RST;
            n_reg         <= '0;
            i_reg         <= '0;
            rd_j_reg      <= '0;
            ev_valid_reg  <= 1'b0;
            ev_j_reg      <= '0;
            k_reg         <= '0;
            rest_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            sup_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            rd_j_reg      <= rd_j_next;
            ev_valid_reg  <= ev_valid_next;
            ev_j_reg      <= ev_j_next;
            k_reg         <= k_next;
            rest_reg      <= rest_next;
            hit_reg       <= hit_next;
            sup_reg       <= sup_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
            if (cfg_we)
            begin
                unique case (bpws_pkg::cfg_reg_t'(cfg_index))
                    bpws_pkg::REG_BOX_COUNT:   box_count_reg <= cfg_data[4:0];
                    bpws_pkg::REG_TIME_STEP:   time_step_reg <= cfg_data[15:0];
                    bpws_pkg::REG_GRAVITY:     gravity_reg   <= cfg_data;
                    bpws_pkg::REG_STOP_THRESH: thresh_reg    <= cfg_data;
                    default:                   thresh_reg    <= thresh_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_idx_reg <= op_idx_next;
        ci_reg     <= ci_next;
        ei_reg     <= ei_next;
        fi_reg     <= fi_next;
        vi_reg     <= vi_next;
        prod_reg   <= prod_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.out_index    = out_reg.index;
    assign rsp.out_center_x = out_reg.center[0];
    assign rsp.out_center_y = out_reg.center[1];
    assign rsp.out_center_z = out_reg.center[2];
    assign rsp.out_force_x  = out_reg.force_vec[0];
    assign rsp.out_force_y  = out_reg.force_vec[1];
    assign rsp.out_force_z  = out_reg.force_vec[2];
    assign rsp.supported    = out_reg.supported;
    assign rsp.last_box     = out_reg.last_box;

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUP || state_reg == ST_PUSH) |-> rd_j_reg <= n_reg)
        else $error("scan counter ran past the box count");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ECAP) |-> CW'(i_reg) < n_reg)
        else $error("emitted box index outside the boxes in use");

    a_hit_in_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hit_reg) |-> $past(state_reg == ST_PUSH))
        else $error("push flag set outside the push scan");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ECAP && out_free && i_last) |=> state_reg == ST_IDLE)
        else $error("sequencer kept running after the last result");

endmodule

/* tb/sv/box_physics_world_step_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_physics_world_step_unit_tb
// Self-checking bench: drives box loads, force writes, reads and world steps
// through the request channel and compares every result item with a
// fixed-point model of the box table kept inside a small scoreboard.
// ----------------------------------------------------------------------------
module box_physics_world_step_unit_tb;

    typedef struct {
        bpws_pkg::op_t   op;
        logic [3:0]      idx;
        bpws_pkg::vec3_t c;
        bpws_pkg::ext3_t l;
        bpws_pkg::vec3_t p;
    } box_req_t;

    // ------------------------------------------------------------------------
    // Box world model and result store.
    // ------------------------------------------------------------------------
    class box_world_scoreboard;
        int          cen[bpws_pkg::MAX_BOXES][3];
        int unsigned ext[bpws_pkg::MAX_BOXES][3];
        int          frc[bpws_pkg::MAX_BOXES][3];
        int unsigned box_count;
        int unsigned time_step;
        int unsigned gravity;
        int unsigned stop_thresh;
        bpws_pkg::out_item_t box_reports[$];
        int          errors;

        function new();
            box_count   = 0;
            time_step   = bpws_pkg::TIME_STEP_RST;
            gravity     = bpws_pkg::GRAVITY_RST;
            stop_thresh = bpws_pkg::THRESH_RST;
            errors      = 0;
        endfunction

        function void configure(bpws_pkg::cfg_reg_t r, int unsigned v);
            case (r)
                bpws_pkg::REG_BOX_COUNT:   box_count   = v & 32'h1F;
                bpws_pkg::REG_TIME_STEP:   time_step   = v & 32'hFFFF;
                bpws_pkg::REG_GRAVITY:     gravity     = v & 32'hFFFFF;
                bpws_pkg::REG_STOP_THRESH: stop_thresh = v & 32'hFFFFF;
            endcase
        endfunction

        // force times time step, rounded to nearest with halves away from zero
        function longint scaled(int f);
            longint p;
            longint mag;
            longint r;
            p   = longint'(f) * longint'(time_step);
            mag = (p < 0) ? -p : p;
            r   = (mag + 64'sd32768) >>> 16;
            return (p < 0) ? -r : r;
        endfunction

        function bit span_hit(int a, longint la, int b, longint lb);
            longint a2;
            longint b2;
            a2 = 2 * longint'(a);
            b2 = 2 * longint'(b);
            return !((a2 + la < b2 - lb) || (a2 - la > b2 + lb));
        endfunction

        function bit overlap(int i, int j);
            for (int k = 0; k < 3; k++)
            begin
                if (!span_hit(cen[i][k], ext[i][k], cen[j][k], ext[j][k]))
                    return 0;
            end
            return 1;
        endfunction

        function bit rests_over(int i, int j);
            return span_hit(cen[i][0], 0, cen[j][0], ext[j][0]) &&
                   span_hit(cen[i][2], 0, cen[j][2], ext[j][2]);
        endfunction

        function void report(int i, bit sup, bit last);
            bpws_pkg::out_item_t e;
            e.index = i[3:0];
            for (int k = 0; k < 3; k++)
            begin
                e.center[k]    = cen[i][k];
                e.force_vec[k] = frc[i][k];
            end
            e.supported = sup;
            e.last_box  = last;
            box_reports.insert(box_reports.size(), e);
        endfunction

        function void world_step();
            int     n;
            bit     sup[bpws_pkg::MAX_BOXES];
            bit     rest;
            bit     hit;
            longint v;
            n = (box_count > bpws_pkg::MAX_BOXES) ? bpws_pkg::MAX_BOXES : box_count;
            for (int i = 0; i < n; i++)
            begin
                rest = 1;
                if (2 * longint'(cen[i][1]) - longint'(ext[i][1]) > 0)
                begin
                    rest = 0;
                    for (int j = 0; j < n && !rest; j++)
                        if (j != i && overlap(i, j) && rests_over(i, j))
                            rest = 1;
                end
                sup[i] = rest;
                cen[i][0] = int'(longint'(cen[i][0]) + scaled(frc[i][0]));
                cen[i][1] = int'(longint'(cen[i][1]) + scaled(frc[i][1])
                                 - (rest ? 64'sd0 : longint'(gravity)));
                cen[i][2] = int'(longint'(cen[i][2]) + scaled(frc[i][2]));
                hit = 0;
                for (int j = 0; j < n; j++)
                begin
                    if (j != i && overlap(i, j))
                    begin
                        for (int k = 0; k < 3; k++)
                            frc[j][k] = frc[i][k] >>> 1;
                        hit = 1;
                    end
                end
                for (int k = 0; k < 3; k++)
                begin
                    v = hit ? 64'sd0 : longint'(frc[i][k]);
                    v = v - scaled(int'(v));
                    if (((v < 0) ? -v : v) < longint'(stop_thresh))
                        v = 0;
                    frc[i][k] = int'(v);
                end
            end
            for (int i = 0; i < n; i++)
                report(i, sup[i], i + 1 == n);
        endfunction

        function void note_request(box_req_t r);
            case (r.op)
                bpws_pkg::OP_LOAD, bpws_pkg::OP_SET_FORCE:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        if (r.op == bpws_pkg::OP_LOAD)
                        begin
                            cen[r.idx][k] = r.c[k];
                            ext[r.idx][k] = {1'b0, r.l[k]};
                        end
                        frc[r.idx][k] = r.p[k];
                    end
                    report(r.idx, 0, 1);
                end
                bpws_pkg::OP_READ: report(r.idx, 0, 1);
                default: world_step();
            endcase
        endfunction

        function void field(string name, longint e, longint a);
            if (e != a)
            begin
                errors++;
                $display("%0t ns: %s mismatch: expected %0d, actual %0d",
                         $time, name, e, a);
            end
        endfunction

        function void check_result(bpws_pkg::out_item_t a);
            bpws_pkg::out_item_t e;
            if (box_reports.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result item for box %0d", $time, a.index);
                return;
            end
            e = box_reports.pop_front();
            field("out_index", e.index, a.index);
            field("out_center_x", e.center[0], a.center[0]);
            field("out_center_y", e.center[1], a.center[1]);
            field("out_center_z", e.center[2], a.center[2]);
            field("out_force_x", e.force_vec[0], a.force_vec[0]);
            field("out_force_y", e.force_vec[1], a.force_vec[1]);
            field("out_force_z", e.force_vec[2], a.force_vec[2]);
            field("supported", e.supported, a.supported);
            field("last_box", e.last_box, a.last_box);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block and channels.
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [19:0] cfg_data;

    bpws_req_if req ();
    bpws_rsp_if rsp ();

    box_physics_world_step_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    box_world_scoreboard sb = new();
    int  burst_left = 4;
    bit  hold_off_req = 0;

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #40ms;
        $display("box_physics_world_step_unit regression: fail");
        $finish;
    end

    // Receiver: the ready pattern periodically picks a random mode; one long hold-off
    // lets the block back up into its request side.
    initial
    begin
        int cyc;
        int mode;
        int hold_cnt;
        cyc      = 0;
        mode     = 0;
        hold_cnt = 0;
        rsp.ready = 0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 64 == 0)
                mode = $urandom_range(0, 2);
            if (hold_off_req && hold_cnt == 0)
            begin
                hold_cnt     = 400;
                hold_off_req = 0;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                rsp.ready <= 1'b0;
            end
            else if (mode == 0)
                rsp.ready <= 1'b1;
            else if (mode == 1)
                rsp.ready <= $urandom_range(0, 1);
            else
                rsp.ready <= ($urandom_range(0, 4) == 0);
        end
    end

    always @(posedge clk)
    begin
        bpws_pkg::out_item_t a;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            a.index        = rsp.out_index;
            a.center[0]    = rsp.out_center_x;
            a.center[1]    = rsp.out_center_y;
            a.center[2]    = rsp.out_center_z;
            a.force_vec[0] = rsp.out_force_x;
            a.force_vec[1] = rsp.out_force_y;
            a.force_vec[2] = rsp.out_force_z;
            a.supported    = rsp.supported;
            a.last_box     = rsp.last_box;
            sb.check_result(a);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers.
    // ------------------------------------------------------------------------
    task automatic send_req(box_req_t r);
        @(negedge clk);
        req.valid     <= 1'b1;
        req.operation <= r.op;
        req.box_index <= r.idx;
        req.center_x  <= r.c[0];
        req.center_y  <= r.c[1];
        req.center_z  <= r.c[2];
        req.length_x  <= r.l[0];
        req.length_y  <= r.l[1];
        req.length_z  <= r.l[2];
        req.push_x    <= r.p[0];
        req.push_y    <= r.p[1];
        req.push_z    <= r.p[2];
        do
            @(posedge clk);
        while (!req.ready);
        sb.note_request(r);
        burst_left--;
        if (burst_left <= 0)
        begin
            @(negedge clk);
            req.valid <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 10);
        end
    endtask

    task automatic cfg_write(bpws_pkg::cfg_reg_t r, int unsigned v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v[19:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.configure(r, v);
    endtask

    // All results in, then a margin for a step that gives no result.
    task automatic settle();
        @(negedge clk);
        req.valid <= 1'b0;
        while (sb.box_reports.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic box_req_t mk(bpws_pkg::op_t op, int idx, int cx, int cy, int cz,
                                    int unsigned lx, int unsigned ly, int unsigned lz,
                                    int px, int py, int pz);
        box_req_t r;
        r.op  = op;
        r.idx = idx[3:0];
        r.c[0] = cx; r.c[1] = cy; r.c[2] = cz;
        r.l[0] = lx[30:0]; r.l[1] = ly[30:0]; r.l[2] = lz[30:0];
        r.p[0] = px; r.p[1] = py; r.p[2] = pz;
        return r;
    endfunction

    function automatic int near(int units);
        return int'($urandom_range(0, 2 * units * 65536)) - units * 65536;
    endfunction

    function automatic box_req_t random_req();
        int       pick;
        box_req_t r;
        pick = $urandom_range(0, 99);
        r = mk(bpws_pkg::OP_READ, $urandom_range(0, 15), $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (pick < 40)
        begin
            r.op = bpws_pkg::OP_LOAD;
            // Mostly small boxes close together so that they stack and collide.
            if ($urandom_range(0, 6) != 0)
            begin
                r.c[0] = near(6);
                r.c[1] = $urandom_range(0, 6 * 65536);
                r.c[2] = near(6);
                for (int k = 0; k < 3; k++)
                begin
                    r.l[k] = 31'($urandom_range(32768, 4 * 65536));
                    r.p[k] = ($urandom_range(0, 3) == 0) ? 0 : near(4);
                end
            end
        end
        else if (pick < 60)
        begin
            r.op = bpws_pkg::OP_SET_FORCE;
            if ($urandom_range(0, 7) != 0)
                for (int k = 0; k < 3; k++)
                    r.p[k] = near(8);
        end
        else if (pick < 75)
            r.op = bpws_pkg::OP_STEP;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    localparam int U = 65536;

    initial
    begin
        rst_n         = 0;
        cfg_we        = 0;
        cfg_index     = bpws_pkg::REG_BOX_COUNT;
        cfg_data      = '0;
        req.valid     = 0;
        req.operation = bpws_pkg::OP_READ;
        req.box_index = '0;
        req.center_x  = '0;
        req.center_y  = '0;
        req.center_z  = '0;
        req.length_x  = '0;
        req.length_y  = '0;
        req.length_z  = '0;
        req.push_x    = '0;
        req.push_y    = '0;
        req.push_z    = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Every box is loaded before anything reads or steps it.
        send_req(mk(bpws_pkg::OP_LOAD, 0, 0, 0, 0, 20 * U, U, 20 * U, 0, 0, 0));
        send_req(mk(bpws_pkg::OP_LOAD, 1, 0, U, 0, U, U, U, U, 0, 0));
        send_req(mk(bpws_pkg::OP_LOAD, 2, 5 * U, 4 * U, 0, U, U, U, 0, -U, 0));
        for (int i = 3; i < 14; i++)
            send_req(mk(bpws_pkg::OP_LOAD, i, near(6), $urandom_range(0, 6 * U), near(6),
                        U, 2 * U, U, near(3), near(3), near(3)));
        send_req(mk(bpws_pkg::OP_LOAD, 14, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                    31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF,
                    32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
        send_req(mk(bpws_pkg::OP_LOAD, 15, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                    0, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000));
        // Empty world: no result.
        send_req(mk(bpws_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_req(mk(bpws_pkg::OP_READ, 14, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_req(mk(bpws_pkg::OP_SET_FORCE, 2, 0, 0, 0, 0, 0, 0, 2 * U, -3 * U, U));
        settle();
        cfg_write(bpws_pkg::REG_BOX_COUNT, 3);
        send_req(mk(bpws_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_req(mk(bpws_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        settle();
        // A count above the table size acts as a full table.
        cfg_write(bpws_pkg::REG_BOX_COUNT, 31);
        send_req(mk(bpws_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_req(mk(bpws_pkg::OP_READ, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        settle();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    cfg_write(bpws_pkg::REG_BOX_COUNT, 16);
                    cfg_write(bpws_pkg::REG_TIME_STEP, 65535);
                    cfg_write(bpws_pkg::REG_GRAVITY, 20'hFFFFF);
                    cfg_write(bpws_pkg::REG_STOP_THRESH, 20'hFFFFF);
                end
                1:
                begin
                    cfg_write(bpws_pkg::REG_BOX_COUNT, 1);
                    cfg_write(bpws_pkg::REG_TIME_STEP, 0);
                    cfg_write(bpws_pkg::REG_GRAVITY, 0);
                    cfg_write(bpws_pkg::REG_STOP_THRESH, 0);
                end
                2:
                begin
                    cfg_write(bpws_pkg::REG_BOX_COUNT, 16);
                    cfg_write(bpws_pkg::REG_TIME_STEP, $urandom_range(500, 8000));
                    cfg_write(bpws_pkg::REG_GRAVITY, $urandom_range(0, 40000));
                    cfg_write(bpws_pkg::REG_STOP_THRESH, $urandom_range(0, 20000));
                    hold_off_req = 1;
                end
                default:
                begin
                    cfg_write(bpws_pkg::REG_BOX_COUNT,
                              (ph == 5) ? 20 : $urandom_range(0, 16));
                    cfg_write(bpws_pkg::REG_TIME_STEP, $urandom_range(0, 65535));
                    cfg_write(bpws_pkg::REG_GRAVITY, $urandom_range(0, 20'hFFFFF));
                    cfg_write(bpws_pkg::REG_STOP_THRESH, $urandom_range(0, 20000));
                end
            endcase
            for (int n = 0; n < 60; n++)
                send_req(random_req());
            settle();
        end

        if (sb.errors == 0)
            $display("box_physics_world_step_unit regression: pass");
        else
            $display("box_physics_world_step_unit regression: fail");
        $finish;
    end

endmodule
